[rtl/tilt_pkg.sv]
package tilt_pkg;

  // default configuration
  localparam int CORDIC_STEPS_DEF = 14;
  localparam int SAMPLE_BITS_DEF  = 16;

  // angle accumulator: signed, 20 fraction bits
  localparam int ACC_W         = 24;
  localparam int ANG_FRAC_BITS = 20;
  localparam int OUT_FRAC_BITS = 12;
  localparam int PI_ACC        = 3294199;
  localparam int PI_Q12        = 12868;
  localparam int ATAN_LEN      = 20;

  // result beat layout
  localparam int ANGLE_W     = 15;
  localparam int OUT_TDATA_W = 32;

  // atan(2^-i) in accumulator units, rounded to nearest
  function automatic logic signed [ACC_W-1:0] atan_step(input int idx);
    logic signed [ACC_W-1:0] val;
    case (idx)
      0:       val = ACC_W'(823550);
      1:       val = ACC_W'(486170);
      2:       val = ACC_W'(256879);
      3:       val = ACC_W'(130396);
      4:       val = ACC_W'(65451);
      5:       val = ACC_W'(32757);
      6:       val = ACC_W'(16383);
      7:       val = ACC_W'(8192);
      8:       val = ACC_W'(4096);
      9:       val = ACC_W'(2048);
      10:      val = ACC_W'(1024);
      11:      val = ACC_W'(512);
      12:      val = ACC_W'(256);
      13:      val = ACC_W'(128);
      14:      val = ACC_W'(64);
      15:      val = ACC_W'(32);
      16:      val = ACC_W'(16);
      17:      val = ACC_W'(8);
      18:      val = ACC_W'(4);
      19:      val = ACC_W'(2);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

[rtl/tilt_angles_atan2.sv]
// Tilt angles from one accelerometer sample. Each input beat carries a signed
// (x, y, z) sample; each output beat carries alpha = atan2(x, z) and
// beta = atan2(y, z) as signed Q3.12 radians, clamped to -12868..12868, with
// 0 returned when numerator and z are both zero. Both angles come from two
// parallel CORDIC vectoring chains: a pre-rotation register, CORDIC_STEPS
// micro-rotation cells and an output register. The chain takes one sample
// every cycle; it only holds while a finished result waits on m_axis_tready,
// and then the whole chain stalls together.
module tilt_angles_atan2
  import tilt_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // accel_x, accel_y, accel_z, zero fill to whole bytes
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // angle_alpha, angle_beta, zero fill
  output logic [OUT_TDATA_W-1:0]                m_axis_tdata
);

  localparam int DP_W  = SAMPLE_BITS + CORDIC_STEPS + 3;
  localparam int N_LANE = 2;

  logic                          adv;
  logic [CORDIC_STEPS:0]         vld;
  logic signed [SAMPLE_BITS-1:0] ax;
  logic signed [SAMPLE_BITS-1:0] ay;
  logic signed [SAMPLE_BITS-1:0] az;
  logic signed [SAMPLE_BITS-1:0] num [N_LANE];

  logic                          zc   [N_LANE][CORDIC_STEPS+1];
  logic signed [DP_W-1:0]        xc   [N_LANE][CORDIC_STEPS+1];
  logic signed [DP_W-1:0]        yc   [N_LANE][CORDIC_STEPS+1];
  logic signed [ACC_W-1:0]       accc [N_LANE][CORDIC_STEPS+1];
  logic signed [ANGLE_W-1:0]     angle [N_LANE];

  // chain moves whenever the output register is free or being taken
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  assign ax     = s_axis_tdata[SAMPLE_BITS-1:0];
  assign ay     = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign az     = s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
  assign num[0] = ax;
  assign num[1] = ay;

  // valid bits travel beside the cells
  always_ff @(posedge clk) begin
    if (rst) begin
      vld           <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      vld           <= {vld[CORDIC_STEPS-1:0], s_axis_tvalid};
      m_axis_tvalid <= vld[CORDIC_STEPS];
    end
  end

  // one chain per angle
  for (genvar l = 0; l < N_LANE; l++) begin : g_lane
    tilt_prerot #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .DP_W         (DP_W)
    ) u_prerot (
      .clk  (clk),
      .en   (adv),
      .num  (num[l]),
      .den  (az),
      .zero (zc[l][0]),
      .x    (xc[l][0]),
      .y    (yc[l][0]),
      .acc  (accc[l][0])
    );

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cell
      tilt_cell #(
        .STAGE (s),
        .DP_W  (DP_W)
      ) u_cell (
        .clk     (clk),
        .en      (adv),
        .zero_in (zc[l][s]),
        .x_in    (xc[l][s]),
        .y_in    (yc[l][s]),
        .acc_in  (accc[l][s]),
        .zero    (zc[l][s+1]),
        .x       (xc[l][s+1]),
        .y       (yc[l][s+1]),
        .acc     (accc[l][s+1])
      );
    end

    tilt_post u_post (
      .clk     (clk),
      .en      (adv),
      .zero_in (zc[l][CORDIC_STEPS]),
      .acc_in  (accc[l][CORDIC_STEPS]),
      .angle   (angle[l])
    );
  end

  // result beat packing
  assign m_axis_tdata = {{(OUT_TDATA_W - 2*ANGLE_W){1'b0}}, angle[1], angle[0]};

endmodule

[rtl/tilt_prerot.sv]
module tilt_prerot
  import tilt_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int DP_W         = SAMPLE_BITS + CORDIC_STEPS + 3
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] num,
  input  logic signed [SAMPLE_BITS-1:0] den,
  output logic                          zero,
  output logic signed [DP_W-1:0]        x,
  output logic signed [DP_W-1:0]        y,
  output logic signed [ACC_W-1:0]       acc
);

  logic signed [DP_W-1:0]  num_ext;
  logic signed [DP_W-1:0]  den_ext;
  logic signed [DP_W-1:0]  x_next;
  logic signed [DP_W-1:0]  y_next;
  logic signed [ACC_W-1:0] acc_next;

  assign num_ext = DP_W'(num);
  assign den_ext = DP_W'(den);

  // half turn for a negative denominator, then scale up
  always_comb begin
    if (den[SAMPLE_BITS-1]) begin
      x_next   = (-den_ext) <<< CORDIC_STEPS;
      y_next   = (-num_ext) <<< CORDIC_STEPS;
      acc_next = num[SAMPLE_BITS-1] ? -ACC_W'(PI_ACC) : ACC_W'(PI_ACC);
    end else begin
      x_next   = den_ext <<< CORDIC_STEPS;
      y_next   = num_ext <<< CORDIC_STEPS;
      acc_next = '0;
    end
  end

  // front register of the chain
  always_ff @(posedge clk) begin
    if (en) begin
      zero <= (num == '0) && (den == '0);
      x    <= x_next;
      y    <= y_next;
      acc  <= acc_next;
    end
  end

endmodule

[rtl/tilt_cell.sv]
module tilt_cell
  import tilt_pkg::*;
#(
  parameter int STAGE = 0,
  parameter int DP_W  = SAMPLE_BITS_DEF + CORDIC_STEPS_DEF + 3
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic                    zero_in,
  input  logic signed [DP_W-1:0]  x_in,
  input  logic signed [DP_W-1:0]  y_in,
  input  logic signed [ACC_W-1:0] acc_in,
  output logic                    zero,
  output logic signed [DP_W-1:0]  x,
  output logic signed [DP_W-1:0]  y,
  output logic signed [ACC_W-1:0] acc
);

  localparam logic signed [ACC_W-1:0] ATAN_I = atan_step(STAGE);

  logic signed [DP_W-1:0] x_sh;
  logic signed [DP_W-1:0] y_sh;

  // floor shifts of the old values
  assign x_sh = x_in >>> STAGE;
  assign y_sh = y_in >>> STAGE;

  // one micro-rotation toward the x axis
  always_ff @(posedge clk) begin
    if (en) begin
      zero <= zero_in;
      if (!y_in[DP_W-1]) begin
        x   <= x_in + y_sh;
        y   <= y_in - x_sh;
        acc <= acc_in + ATAN_I;
      end else begin
        x   <= x_in - y_sh;
        y   <= y_in + x_sh;
        acc <= acc_in - ATAN_I;
      end
    end
  end

endmodule

[rtl/tilt_post.sv]
module tilt_post
  import tilt_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic                      zero_in,
  input  logic signed [ACC_W-1:0]   acc_in,
  output logic signed [ANGLE_W-1:0] angle
);

  localparam int RND_SH = ANG_FRAC_BITS - OUT_FRAC_BITS;
  localparam int RND_W  = ACC_W - RND_SH;

  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [RND_W-1:0]   q12;
  logic signed [ANGLE_W-1:0] angle_next;

  // round half up to 12 fraction bits
  assign acc_rnd = acc_in + ACC_W'(1 << (RND_SH - 1));
  assign q12     = RND_W'(acc_rnd >>> RND_SH);

  // clamp to -pi..pi, both-zero sample gives 0
  always_comb begin
    if (zero_in) begin
      angle_next = '0;
    end else if (q12 > RND_W'(PI_Q12)) begin
      angle_next = ANGLE_W'(PI_Q12);
    end else if (q12 < -RND_W'(PI_Q12)) begin
      angle_next = -ANGLE_W'(PI_Q12);
    end else begin
      angle_next = ANGLE_W'(q12);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= angle_next;
    end
  end

endmodule
